// ===== src/hsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types and constants of the Hermite sample player.
// ----------------------------------------------------------------------------
package hsp_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int PITCH_W  = 24;
	localparam int FCOUNT_W = 17;
	localparam int CFG_W    = 24;
	// width of the interpolation datapath values (coefficients, partial sums)
	localparam int IW       = 24;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// operation codes of an input word
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PITCH  = 2'd0,
		CFG_FRAMES = 2'd1,
		CFG_LOOP   = 2'd2,
		CFG_STEREO = 2'd3
	} cfg_idx_t;

	localparam logic [PITCH_W-1:0]  PITCH_RST  = 24'd65536;
	localparam logic [FCOUNT_W-1:0] FRAMES_RST = 17'd65536;

	// saturation bounds in datapath width
	localparam logic signed [IW-1:0] SAT_HI = 24'sd32767;
	localparam logic signed [IW-1:0] SAT_LO = -24'sd32768;

	// four neighboring frames of one channel
	typedef struct packed {
		sample_t xm1;
		sample_t x0;
		sample_t x1;
		sample_t x2;
	} taps_t;

endpackage

// ===== src/hsp_store.sv =====
// ----------------------------------------------------------------------------
// hsp_store
// Single-port sample memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module hsp_store import hsp_pkg::*; #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  sample_t       wdata,
	output sample_t       rdata
);

	sample_t mem [0:DEPTH-1];
	sample_t rdata_q;

	// write or read at one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/hsp_hermite.sv =====
// ----------------------------------------------------------------------------
// hsp_hermite
// One interpolation lane: 4-point Hermite evaluated in Horner form with a
// single multiplier, three multiply / round passes, saturated to 16 bits.
// ----------------------------------------------------------------------------
module hsp_hermite import hsp_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  taps_t                    taps,
	input  logic [FRACTION_BITS-1:0] frac,
	output logic                     done,
	output sample_t                  result
);

	localparam int B  = FRACTION_BITS;
	localparam int PW = IW + B + 2;

	// coefficients
	logic signed [IW-1:0] c2, v, w2, a2, b2;
	logic signed [IW-1:0] c2_q, b2_q, op_q, acc;
	sample_t              x0_q;
	sample_t              res_q;

	// multiply / round sequencing
	logic        busy_q, mul_ph_q, done_q;
	logic [1:0]  pass_q;
	logic        last_pass;

	logic signed [B:0]    fs;
	logic signed [IW+B:0] mul_w;
	logic signed [PW-1:0] prod_q, addend, sum, rnd_b, rnd_b1;

	assign c2 = IW'(taps.x1) - IW'(taps.xm1);
	assign v  = IW'(taps.x0) - IW'(taps.x1);
	assign w2 = c2 + (v <<< 1);
	assign a2 = w2 + (v <<< 1) + (IW'(taps.x2) - IW'(taps.x0));
	assign b2 = w2 + a2;

	assign fs    = $signed({1'b0, frac});
	assign mul_w = op_q * fs;

	// term added before each rounding
	always_comb begin
		unique case (pass_q)
			2'd0:    addend = -(PW'(b2_q) <<< B);
			2'd1:    addend = PW'(c2_q) <<< B;
			default: addend = PW'(x0_q) <<< (B + 1);
		endcase
	end

	assign last_pass = (pass_q == 2'd2);
	assign sum       = prod_q + addend;
	assign rnd_b     = (sum + (PW'(1) <<< (B - 1))) >>> B;
	assign rnd_b1    = (sum + (PW'(1) <<< B)) >>> (B + 1);
	assign acc       = last_pass ? IW'(rnd_b1) : IW'(rnd_b);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			mul_ph_q <= 1'b0;
			done_q   <= 1'b0;
			pass_q   <= '0;
		end else if (start) begin
			busy_q   <= 1'b1;
			mul_ph_q <= 1'b1;
			done_q   <= 1'b0;
			pass_q   <= '0;
		end else if (busy_q) begin
			if (mul_ph_q) begin
				mul_ph_q <= 1'b0;
			end else if (last_pass) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				pass_q   <= pass_q + 2'd1;
				mul_ph_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= a2;
			b2_q <= b2;
			c2_q <= c2;
			x0_q <= taps.x0;
		end else if (busy_q) begin
			if (mul_ph_q) begin
				prod_q <= PW'(mul_w);
			end else begin
				op_q <= acc;
				if (last_pass) begin
					if (acc > SAT_HI) begin
						res_q <= sample_t'(SAT_HI[SAMPLE_W-1:0]);
					end else if (acc < SAT_LO) begin
						res_q <= sample_t'(SAT_LO[SAMPLE_W-1:0]);
					end else begin
						res_q <= acc[SAMPLE_W-1:0];
					end
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== src/hermite_sample_player.sv =====
// ----------------------------------------------------------------------------
// hermite_sample_player
// Sample playback with 4-point cubic Hermite interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (item_valid / item_ready) carry an operation: write sample,
//   start, stop or tick. Only a tick yields a result word (result_valid /
//   result_ready) with left_out, right_out and is_playing.
//   Config is written through cfg_we / cfg_index / cfg_data while idle.
// Sequence:
//   Write, start and stop leave the block idle and ready for the next word.
//   A tick while stopped (or stopping at the end) goes straight to the result load.
//   A playing tick runs setup, 8 back-to-back reads of the single-port store
//   (4 frames x 2 channels), a drain state that lands the last read, launch,
//   the interpolation lanes (3 multiply / round passes each) and the result
//   load.
//   One word is in work at a time; item_ready is high only when idle.
// Reset:
//   Position 0, stopped, registers at their defaults. The sample store is
//   not cleared; samples must be written before they are played.
// Stalls:
//   The result sits in an output register; a new word may be accepted while
//   it waits. A tick finishing while the previous result is still held waits
//   until result_ready frees the register.
// ----------------------------------------------------------------------------
module hermite_sample_player import hsp_pkg::*; #(
	parameter int MAX_FRAMES    = 65536,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// input words
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [1:0]          operation,
	input  logic [16:0]         sample_address,
	input  sample_t             sample_value,
	// result words
	output logic                result_valid,
	input  logic                result_ready,
	output sample_t             left_out,
	output sample_t             right_out,
	output logic                is_playing,
	// configuration
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int B      = FRACTION_BITS;
	localparam int DEPTH  = 2 * MAX_FRAMES;
	localparam int AW     = $clog2(DEPTH);
	localparam int FW     = $clog2(MAX_FRAMES + 1);
	localparam int CW     = (FW > FCOUNT_W) ? FW : FCOUNT_W;
	localparam int POS_W  = FW + B;
	localparam int SUM_W  = ((POS_W > PITCH_W) ? POS_W : PITCH_W) + 1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SETUP  = 7'b0000010,
		ST_READ   = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_LAUNCH = 7'b0010000,
		ST_CALC   = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t state_q;

	// config registers
	logic [PITCH_W-1:0]  pitch_q;
	logic [FCOUNT_W-1:0] frames_q;
	logic                loop_q, stereo_q;

	// playback state
	logic [POS_W-1:0] pos_q;
	logic             playing_q;

	// read sequencing
	logic [FW-1:0]  frame_q;
	logic [2:0]     rd_cnt_q;
	logic           cap_vld_s1;
	logic [2:0]     cap_idx_s1;
	sample_t        samp_q [0:7];

	// output register
	logic    res_vld_q, res_play_q;
	sample_t res_left_q, res_right_q;

	// interpolation lanes
	taps_t   taps_l, taps_r;
	logic    lane_go, done_l, done_r, lane_done;
	sample_t val_l, val_r;

	// effective frame count, clamped to 1..MAX_FRAMES
	logic [FW-1:0] n;
	always_comb begin
		if (frames_q == '0) begin
			n = FW'(1);
		end else if (CW'(frames_q) > CW'(MAX_FRAMES)) begin
			n = FW'(MAX_FRAMES);
		end else begin
			n = FW'(frames_q);
		end
	end

	// handshake
	logic accept, out_free, out_load;
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !res_vld_q || result_ready;
	assign out_load   = (state_q == ST_FIN) && out_free;

	// position advance and end-of-sample wrap
	logic [SUM_W-1:0] pos_sum, limit;
	logic             wrap, play_next;
	assign pos_sum   = SUM_W'(pos_q) + SUM_W'(pitch_q);
	assign limit     = SUM_W'(n) << B;
	assign wrap      = pos_sum > limit;
	assign play_next = playing_q && !(wrap && !loop_q);

	// frame indexes
	logic [FW-1:0] t_idx, xm1_idx, frame_nx;
	assign t_idx    = pos_q[POS_W-1:B];
	assign xm1_idx  = ((t_idx == '0) || (t_idx == n)) ? (n - FW'(1)) : (t_idx - FW'(1));
	assign frame_nx = ((FW + 1)'(frame_q) + (FW + 1)'(1) == (FW + 1)'(n)) ? '0
	                  : (frame_q + FW'(1));

	// store port: reads during the read sweep, otherwise writes
	logic          st_we, rd_ch;
	logic [AW-1:0] st_addr, rd_addr;
	sample_t       st_rdata;

	assign rd_ch   = rd_cnt_q[0] && stereo_q;
	assign rd_addr = stereo_q ? ((AW'(frame_q) << 1) | AW'(rd_ch)) : AW'(frame_q);
	assign st_we   = accept && (operation == OP_WRITE) &&
	                 (32'(sample_address) < 32'(DEPTH));
	assign st_addr = (state_q == ST_READ) ? rd_addr : AW'(sample_address);

	hsp_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.addr  (st_addr),
		.wdata (sample_value),
		.rdata (st_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q  <= PITCH_RST;
			frames_q <= FRAMES_RST;
			loop_q   <= 1'b0;
			stereo_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PITCH:  pitch_q  <= cfg_data[PITCH_W-1:0];
				CFG_FRAMES: frames_q <= cfg_data[FCOUNT_W-1:0];
				CFG_LOOP:   loop_q   <= cfg_data[0];
				CFG_STEREO: stereo_q <= cfg_data[0];
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			playing_q  <= 1'b0;
			frame_q    <= '0;
			rd_cnt_q   <= '0;
			cap_vld_s1 <= 1'b0;
			cap_idx_s1 <= '0;
		end else begin
			cap_vld_s1 <= (state_q == ST_READ);
			cap_idx_s1 <= rd_cnt_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op_t'(operation))
							OP_START: begin
								pos_q     <= '0;
								playing_q <= 1'b1;
							end
							OP_STOP: begin
								playing_q <= 1'b0;
							end
							OP_TICK: begin
								pos_q     <= wrap ? '0 : POS_W'(pos_sum);
								playing_q <= play_next;
								state_q   <= play_next ? ST_SETUP : ST_FIN;
							end
							OP_WRITE: begin
							end
						endcase
					end
				end
				ST_SETUP: begin
					frame_q  <= xm1_idx;
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q[0]) begin
						frame_q <= frame_nx;
					end
					if (rd_cnt_q == 3'd7) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:  state_q <= ST_LAUNCH;
				ST_LAUNCH: state_q <= ST_CALC;
				ST_CALC: begin
					if (lane_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read data capture: even slots left channel, odd slots right channel
	always_ff @(posedge clk) begin
		if (cap_vld_s1) begin
			samp_q[cap_idx_s1] <= st_rdata;
		end
	end

	// interpolation lanes
	assign taps_l  = '{xm1: samp_q[0], x0: samp_q[2], x1: samp_q[4], x2: samp_q[6]};
	assign taps_r  = '{xm1: samp_q[1], x0: samp_q[3], x1: samp_q[5], x2: samp_q[7]};
	assign lane_go = (state_q == ST_LAUNCH);
	assign lane_done = done_l && done_r;

	hsp_hermite #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_go),
		.taps   (taps_l),
		.frac   (pos_q[B-1:0]),
		.done   (done_l),
		.result (val_l)
	);

	hsp_hermite #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_go),
		.taps   (taps_r),
		.frac   (pos_q[B-1:0]),
		.done   (done_r),
		.result (val_r)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_load) begin
			res_vld_q <= 1'b1;
		end else if (result_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_play_q  <= playing_q;
			res_left_q  <= playing_q ? val_l : '0;
			res_right_q <= playing_q ? val_r : '0;
		end
	end

	assign result_valid = res_vld_q;
	assign left_out     = res_left_q;
	assign right_out    = res_right_q;
	assign is_playing   = res_play_q;

endmodule

// ===== src/hsp_checker.sv =====
// ----------------------------------------------------------------------------
// hsp_checker
// Port-level checks of the Hermite sample player, bound to the top level.
// ----------------------------------------------------------------------------
module hsp_checker import hsp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  operation,
	input logic        result_valid,
	input logic        result_ready,
	input sample_t     left_out,
	input sample_t     right_out,
	input logic        is_playing
);

	// a held result word does not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(left_out) && $stable(right_out) &&
			$stable(is_playing))
		else $error("result word changed while stalled");

	// a stopped player reports silence
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_playing |-> (left_out == '0) && (right_out == '0))
		else $error("nonzero output while stopped");

	// an accepted tick takes the block out of idle, so item_ready drops
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (operation == OP_TICK) |=> !item_ready)
		else $error("ready right after a tick");

	// write, start and stop leave the block ready again in the next cycle
	a_ctl_fast: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (operation != OP_TICK) |=> item_ready)
		else $error("not ready after a one-cycle word");

endmodule

bind hermite_sample_player hsp_checker u_hsp_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hermite sample player.
// A short scripted part under the reset settings carries hand-typed results.
// Then come phases of random words, each phase under its own register
// settings, extremes first. A predictor mirrors the store, the position, the
// play flag and the registers; phase result words are checked against it.
// Store entries are written before any tick reads them.
// ----------------------------------------------------------------------------
module testbench;
	import hsp_pkg::*;

	localparam int MAX_FRAMES  = 65536;
	localparam int FRAC_BITS   = 16;
	localparam int STORE_SIZE  = 2 * MAX_FRAMES;
	localparam int SETTLE      = 30;	// covers the slowest word in flight
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 70;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    playing;
	} mix_t;

	typedef struct packed {
		op_t         op;
		logic [16:0] addr;
		sample_t     value;
		logic        typed;
		mix_t        mix;
	} script_row_t;

	// scripted words; the reset settings give 65536 mono frames at unit pitch,
	// so every playing tick lands on a whole frame and plays that sample as is
	localparam int SCRIPT_LEN = 18;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_TICK,  17'd0,      16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_STOP,  17'd0,      16'h0000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd0,      16'h8000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd1,      16'h7FFF, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd2,      16'h0000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd3,      16'hFFFF, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd4,      16'h1234, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd5,      16'h0001, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd131071, 16'h5555, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_START, 17'd0,      16'h0000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_TICK,  17'd0,      16'h0000, 1'b1, '{16'h7FFF, 16'h7FFF, 1'b1}},
		'{OP_TICK,  17'd0,      16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
		'{OP_TICK,  17'd0,      16'h0000, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1}},
		'{OP_STOP,  17'd0,      16'h0000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_TICK,  17'd0,      16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_START, 17'd0,      16'h0000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_WRITE, 17'd1,      16'h8000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
		'{OP_TICK,  17'd0,      16'h0000, 1'b1, '{16'h8000, 16'h8000, 1'b1}}
	};

	// register settings of the first phases: extremes and corner sizes
	localparam int FIXED_PHASES = 9;
	localparam logic [PITCH_W-1:0] PITCH_SET [FIXED_PHASES] = '{
		24'h000000, 24'hFFFFFF, 24'h018000, 24'h004000, 24'h00C123,
		24'hFFFFFF, 24'h7FFFFF, 24'h00FFFF, 24'h010000
	};
	localparam logic [FCOUNT_W-1:0] FRAMES_SET [FIXED_PHASES] = '{
		17'd4, 17'd0, 17'd5, 17'd3, 17'd131071, 17'd65536, 17'd65537, 17'd1, 17'd2
	};
	localparam logic LOOP_SET [FIXED_PHASES] = '{
		1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1
	};
	localparam logic STEREO_SET [FIXED_PHASES] = '{
		1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
	};

	// block ports
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	logic [1:0]       operation = OP_WRITE;
	logic [16:0]      sample_address = '0;
	sample_t          sample_value = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	sample_t          left_out;
	sample_t          right_out;
	logic             is_playing;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = CFG_PITCH;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor state
	sample_t             sample_mem [STORE_SIZE];
	bit                  sample_known [STORE_SIZE];
	longint              play_pos = 0;
	bit                  play_on = 1'b0;
	logic [PITCH_W-1:0]  pitch_reg = PITCH_RST;
	logic [FCOUNT_W-1:0] frames_reg = FRAMES_RST;
	logic                loop_reg = 1'b0;
	logic                stereo_reg = 1'b0;

	mix_t mix_queue [$];	// mixes still owed by the block, oldest first
	int   error_count = 0;
	bit   steady_send = 1'b0;	// no gaps between words
	bit   steady_take = 1'b0;	// no stalls on results

	hermite_sample_player #(
		.MAX_FRAMES(MAX_FRAMES),
		.FRACTION_BITS(FRAC_BITS)
	) dut (.*);

	always #5 clk = ~clk;

	initial begin : watchdog
		#10_000_000;
		$display("timeout: player stopped answering");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int active_frames();
		if (frames_reg == 0) return 1;
		if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
		return int'(frames_reg);
	endfunction

	// divide by 2^s, nearest, ties up
	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic sample_t hermite_at(longint t, longint frac, int n, int chans,
			int chan);
		longint xm1, x0, x1, x2, c2, v, w2, a2, b2, s1, s2, r;
		xm1 = sample_mem[((t + n - 1) % n) * chans + chan];
		x0  = sample_mem[(t % n) * chans + chan];
		x1  = sample_mem[((t + 1) % n) * chans + chan];
		x2  = sample_mem[((t + 2) % n) * chans + chan];
		c2  = x1 - xm1;
		v   = x0 - x1;
		w2  = c2 + 2 * v;
		a2  = w2 + 2 * v + (x2 - x0);
		b2  = w2 + a2;
		// Horner in the fraction, one rounding per pass
		s1  = round_half_up(a2 * frac - (b2 <<< FRAC_BITS), FRAC_BITS);
		s2  = round_half_up(s1 * frac + (c2 <<< FRAC_BITS), FRAC_BITS);
		r   = round_half_up(s2 * frac + (x0 <<< (FRAC_BITS + 1)), FRAC_BITS + 1);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return sample_t'(r);
	endfunction

	// position and play flag as they stand after the next tick
	function automatic void next_tick(output longint pos, output bit on);
		longint limit;
		limit = longint'(active_frames()) <<< FRAC_BITS;
		pos = play_pos + longint'(pitch_reg);
		on = play_on;
		if (pos > limit) begin
			pos = 0;
			if (!loop_reg) on = 1'b0;
		end
	endfunction

	// moves the model by one accepted word; a tick returns 1 with its mix
	function automatic bit player_step(op_t op, logic [16:0] addr, sample_t value,
			output mix_t mix);
		int n, chans;
		longint t, frac;
		mix = '0;
		case (op)
			OP_WRITE: begin
				sample_mem[addr] = value;
				sample_known[addr] = 1'b1;
				return 1'b0;
			end
			OP_START: begin
				play_pos = 0;
				play_on = 1'b1;
				return 1'b0;
			end
			OP_STOP: begin
				play_on = 1'b0;	// position is kept
				return 1'b0;
			end
			default: ;
		endcase
		next_tick(play_pos, play_on);
		if (play_on) begin
			n = active_frames();
			chans = stereo_reg ? 2 : 1;
			t = play_pos >>> FRAC_BITS;
			frac = play_pos & ((longint'(1) <<< FRAC_BITS) - 1);
			mix.left = hermite_at(t, frac, n, chans, 0);
			mix.right = hermite_at(t, frac, n, chans, chans - 1);
			mix.playing = 1'b1;
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic flag_mismatch(string what);
		error_count++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic check_word(mix_t got);
		mix_t want;
		if (mix_queue.size() == 0) begin
			flag_mismatch($sformatf("result word with none owed: L=%0d R=%0d P=%0b",
				$signed(got.left), $signed(got.right), got.playing));
			return;
		end
		want = mix_queue.pop_front();
		if (got.left !== want.left)
			flag_mismatch($sformatf("left_out %0d, predicted %0d",
				$signed(got.left), $signed(want.left)));
		if (got.right !== want.right)
			flag_mismatch($sformatf("right_out %0d, predicted %0d",
				$signed(got.right), $signed(want.right)));
		if (got.playing !== want.playing)
			flag_mismatch($sformatf("is_playing %0b, predicted %0b",
				got.playing, want.playing));
	endtask

	// result side: random stall before each word, then take it
	initial begin : take_results
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady_take ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			check_word({left_out, right_out, is_playing});
		end
	end

	// ---------------------------------------------------------------- stimulus

	// one word through the handshake; called at a rising edge
	task automatic send_word(op_t op, logic [16:0] addr, sample_t value,
			bit typed = 1'b0, mix_t typed_mix = '0);
		int gap;
		mix_t mix;
		gap = steady_send ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid     <= 1'b1;
		operation      <= op;
		sample_address <= addr;
		sample_value   <= value;
		do @(posedge clk); while (!item_ready);
		if (player_step(op, addr, value, mix)) mix_queue.push_back(typed ? typed_mix : mix);
	endtask

	// tick, after filling any store entry it will read that holds no sample yet
	task automatic send_tick();
		longint pos, t;
		bit on;
		int n, chans, addr;
		next_tick(pos, on);
		if (on) begin
			n = active_frames();
			chans = stereo_reg ? 2 : 1;
			t = pos >>> FRAC_BITS;
			for (int k = -1; k <= 2; k++)
				for (int c = 0; c < chans; c++) begin
					addr = int'(((t + n + k) % n) * chans + c);
					if (!sample_known[addr])
						send_word(OP_WRITE, addr[16:0], sample_t'($urandom));
				end
		end
		// address and value are don't-care on a tick
		send_word(OP_TICK, 17'($urandom), sample_t'($urandom));
	endtask

	// mostly play sequences: start when stopped, ticks while playing,
	// with writes and stops mixed in
	task automatic random_word();
		int pick, span;
		op_t op;
		pick = $urandom_range(0, 99);
		span = active_frames() * (stereo_reg ? 2 : 1);
		if (!play_on)
			op = (pick < 40) ? OP_START : (pick < 70) ? OP_TICK : (pick < 90) ? OP_WRITE : OP_STOP;
		else
			op = (pick < 75) ? OP_TICK : (pick < 85) ? OP_WRITE : (pick < 92) ? OP_STOP : OP_START;
		case (op)
			OP_TICK:  send_tick();
			OP_WRITE: send_word(OP_WRITE,
				$urandom_range(0, 1) ? 17'($urandom_range(0, span - 1)) : 17'($urandom),
				sample_t'($urandom));
			default:  send_word(op, 17'($urandom), sample_t'($urandom));
		endcase
	endtask

	// hold off new words until every owed result is in
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (mix_queue.size() != 0);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// new register settings, only once the player has gone quiet;
	// bits above each register's width carry junk
	task automatic load_settings(logic [PITCH_W-1:0] pitch, logic [FCOUNT_W-1:0] frames,
			logic loop_on, logic two_ch);
		drain();
		repeat (SETTLE) @(posedge clk);
		put_reg(CFG_PITCH, pitch);
		put_reg(CFG_FRAMES, {7'($urandom), frames});
		put_reg(CFG_LOOP, {23'($urandom), loop_on});
		put_reg(CFG_STEREO, {23'($urandom), two_ch});
		cfg_we <= 1'b0;
		pitch_reg  = pitch;
		frames_reg = frames;
		loop_reg   = loop_on;
		stereo_reg = two_ch;
	endtask

	initial begin : stimulus
		int final_wait;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted words under the reset settings
		for (int i = 0; i < SCRIPT_LEN; i++)
			send_word(SCRIPT[i].op, SCRIPT[i].addr, SCRIPT[i].value,
				SCRIPT[i].typed, SCRIPT[i].mix);

		// random phases, fixed corner settings first
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < FIXED_PHASES)
				load_settings(PITCH_SET[ph], FRAMES_SET[ph], LOOP_SET[ph], STEREO_SET[ph]);
			else
				load_settings(
					($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h3FFFF)),
					($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(1, 12)),
					1'($urandom), 1'($urandom));
			steady_send = ($urandom_range(0, 2) == 0);
			steady_take = ($urandom_range(0, 2) == 0);
			repeat (PHASE_WORDS) begin
				random_word();
				if ($urandom_range(0, 59) == 0) drain();
			end
		end

		// let the last results come back, then a quiet stretch
		item_valid <= 1'b0;
		final_wait = 0;
		do begin
			@(posedge clk);
			final_wait++;
		end while (mix_queue.size() != 0 && final_wait < 5000);
		repeat (SETTLE) @(posedge clk);
		if (mix_queue.size() != 0)
			flag_mismatch($sformatf("%0d result words never came", mix_queue.size()));

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
